[design/nfha_pkg.sv]
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and constants of the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam int POOL_BYTES_DEF    = 65536;
	localparam int SEGMENT_BYTES_DEF = 16384;

	localparam int HDR_BYTES = 4;
	localparam int MIN_SPLIT = 8;
	localparam int COUNT_W   = 14;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NULL = 2'd1;
	localparam logic [1:0] STAT_OOM  = 2'd2;
	localparam logic [1:0] STAT_BAD  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_SEG,
		ST_IDLE,
		ST_A_STEP,
		ST_A_CHK,
		ST_A_SPLIT,
		ST_F_SZ,
		ST_F_STEP,
		ST_F_FWD,
		ST_F_RDQ,
		ST_F_BWD,
		ST_DONE
	} nfha_state_t;

endpackage

[design/nfha_ram.sv]
// ----------------------------------------------------------------------------
// nfha_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/nfha_seg.sv]
// ----------------------------------------------------------------------------
// nfha_seg
// Segment base of an address: reciprocal multiply, back-multiply, one
// correction step, each registered in turn.
// ----------------------------------------------------------------------------
module nfha_seg #(
	parameter int ADDR_W        = 16,
	parameter int SEGMENT_BYTES = 16384
) (
	input  logic              clk,
	input  logic              load,
	input  logic [ADDR_W-1:0] addr,
	output logic [ADDR_W-1:0] seg_base
);

	localparam int SH = ADDR_W + $clog2(SEGMENT_BYTES);
	localparam int MW = ADDR_W + 1;
	localparam int PW = ADDR_W + MW;
	localparam int SW = 24;
	localparam int CW = ADDR_W + SW;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 64'(SEGMENT_BYTES));
	localparam logic [SW-1:0] SEG_C = SW'(SEGMENT_BYTES);

	logic [ADDR_W-1:0] addr_s1;
	logic [PW-1:0]     prod_s1;
	logic [ADDR_W-1:0] addr_s2;
	logic [ADDR_W-1:0] base_s2;
	logic [ADDR_W-1:0] quot;
	logic [CW-1:0]     back;
	logic [ADDR_W-1:0] rem;

	assign quot = ADDR_W'(prod_s1 >> SH);
	assign back = CW'(quot) * CW'(SEG_C);
	assign rem  = addr_s2 - base_s2;

	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1 <= addr;
			prod_s1 <= PW'(addr) * PW'(RECIP);
		end
		addr_s2 <= addr_s1;
		base_s2 <= back[ADDR_W-1:0];
		if (CW'(rem) >= CW'(SEG_C)) begin
			seg_base <= base_s2 + ADDR_W'(SEGMENT_BYTES);
		end else begin
			seg_base <= base_s2;
		end
	end

endmodule

[design/next_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit allocator over an address-ordered free list held in header RAMs.
// Allocate visits free blocks from the rover one by one, with a split step
// when a block is split. Free walks past the free blocks below the address;
// null and unaligned pointers, and blocks past the pool end, skip the walk.
// One item at a time; a new item waits until the result is handed on. A
// stalled result holds the input. A clearing pass over POOL_BYTES/4 words after
// reset and a write per segment build the blocks; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator #(
	parameter int POOL_BYTES    = nfha_pkg::POOL_BYTES_DEF,
	parameter int SEGMENT_BYTES = nfha_pkg::SEGMENT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] request_bytes,
	input  logic [15:0] free_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] block_address,
	output logic [1:0]  status
);

	import nfha_pkg::*;

	localparam int AW      = $clog2(POOL_BYTES);
	localparam int DW      = ((AW > 17) ? AW : 17) + 1;
	localparam int EW      = DW + 24;
	localparam int WORDS   = POOL_BYTES / 4;
	localparam int IW      = $clog2(WORDS);
	localparam int SPAN0   = POOL_BYTES - (POOL_BYTES % 4);
	localparam int TAIL    = SPAN0 % SEGMENT_BYTES;
	localparam int SPAN1   = (TAIL < MIN_SPLIT) ? (SPAN0 - TAIL) : SPAN0;
	localparam int SENT    = SPAN1 - MIN_SPLIT;
	localparam int NSEG    = (SENT + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
	localparam int CNT_RST = (NSEG + 1) % (1 << COUNT_W);

	localparam logic [DW-1:0] SENT_C = DW'(SENT);
	localparam logic [DW-1:0] HDR_C  = DW'(HDR_BYTES);

	nfha_state_t state_q, state_d;

	logic [IW-1:0]      clr_q, clr_d;
	logic [DW-1:0]      base_q, base_d;
	logic [DW-1:0]      rover_q, rover_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] n_q, n_d;
	logic [DW-1:0]      p_q, p_d, q_q, q_d, x_q, x_d;
	logic [DW-1:0]      need_q, need_d, sz_q, sz_d;
	logic [DW-1:0]      fsz_q, fsz_d, flink_q, flink_d;
	logic               fwd_q, fwd_d;
	logic [15:0]        res_addr_q, res_addr_d;
	logic [1:0]         res_stat_q, res_stat_d;
	logic               out_valid_q, out_valid_d;
	logic [15:0]        block_address_q, block_address_d;
	logic [1:0]         status_q, status_d;

	logic          size_we, link_we;
	logic [IW-1:0] size_wa, link_wa, rd_idx;
	logic [DW-1:0] size_wd, link_wd, size_rd, link_rd;

	logic [AW-1:0] seg_base_a;
	logic [DW-1:0] seg_base;

	logic [DW-1:0] need_w, x_w, k_w, left_w, piece_w;
	logic [DW:0]   xsz_w;
	logic          fr_bad, lnk_bad, s_lt, k_small, walk_more, seg_last;
	logic          p_in_seg, q_in_seg, fwd, bwd, slot_free;

	nfha_ram #(.WIDTH(DW), .DEPTH(WORDS)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_wa),
		.wdata (size_wd),
		.raddr (rd_idx),
		.rdata (size_rd)
	);

	nfha_ram #(.WIDTH(DW), .DEPTH(WORDS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_wa),
		.wdata (link_wd),
		.raddr (rd_idx),
		.rdata (link_rd)
	);

	nfha_seg #(.ADDR_W(AW), .SEGMENT_BYTES(SEGMENT_BYTES)) u_seg (
		.clk      (clk),
		.load     (state_q == ST_IDLE && in_valid),
		.addr     (x_w[AW-1:0]),
		.seg_base (seg_base_a)
	);

	assign seg_base = DW'(seg_base_a);

	assign need_w    = (DW'(request_bytes) + HDR_C + DW'(3)) & ~DW'(3);
	assign x_w       = DW'(free_address) - HDR_C;
	assign fr_bad    = (free_address[1:0] != 2'd0) || (free_address < 16'(HDR_BYTES))
			|| (x_w > SENT_C);
	assign lnk_bad   = link_rd > SENT_C;
	assign s_lt      = size_rd < need_q;
	assign k_w       = size_rd - need_q;
	assign k_small   = k_w < DW'(MIN_SPLIT);
	assign walk_more = (n_q != '0) && s_lt;
	assign xsz_w     = {1'b0, x_q} + {1'b0, size_rd};
	assign left_w    = SENT_C - base_q;
	assign piece_w   = (EW'(left_w) > EW'(SEGMENT_BYTES)) ? DW'(SEGMENT_BYTES) : left_w;
	assign seg_last  = (base_q + piece_w) == SENT_C;
	assign p_in_seg  = (p_q >= seg_base) && (EW'(p_q - seg_base) < EW'(SEGMENT_BYTES));
	assign q_in_seg  = (q_q >= seg_base) && (EW'(q_q - seg_base) < EW'(SEGMENT_BYTES));
	assign fwd       = p_in_seg && ({1'b0, p_q} == ({1'b0, x_q} + {1'b0, sz_q}))
			&& (p_q != SENT_C);
	assign bwd       = q_in_seg && ({1'b0, x_q} == ({1'b0, q_q} + {1'b0, size_rd}))
			&& (q_q != SENT_C);
	assign slot_free = !out_valid_q || !out_stall;

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign block_address = block_address_q;
	assign status        = status_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == IW'(WORDS - 1)) state_d = ST_SEG;
			end
			ST_SEG: begin
				if (seg_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						KIND_ALLOC: state_d = (request_bytes == '0) ? ST_DONE : ST_A_STEP;
						KIND_FREE: begin
							if (free_address == '0 || fr_bad) state_d = ST_DONE;
							else state_d = ST_F_SZ;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_A_STEP: begin
				state_d = (lnk_bad || n_q == '0) ? ST_DONE : ST_A_CHK;
			end
			ST_A_CHK: begin
				priority if (walk_more) state_d = lnk_bad ? ST_DONE : ST_A_CHK;
				else if (s_lt || k_small) state_d = ST_DONE;
				else state_d = ST_A_SPLIT;
			end
			ST_A_SPLIT: state_d = ST_DONE;
			ST_F_SZ: begin
				state_d = (xsz_w > {1'b0, SENT_C}) ? ST_DONE : ST_F_STEP;
			end
			ST_F_STEP: begin
				priority if (lnk_bad || n_q == '0) state_d = ST_DONE;
				else if (link_rd <= x_q) state_d = ST_F_STEP;
				else state_d = ST_F_FWD;
			end
			ST_F_FWD: state_d = ST_F_RDQ;
			ST_F_RDQ: state_d = ST_F_BWD;
			ST_F_BWD: state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		clr_d           = clr_q;
		base_d          = base_q;
		rover_d         = rover_q;
		count_d         = count_q;
		n_d             = n_q;
		p_d             = p_q;
		q_d             = q_q;
		x_d             = x_q;
		need_d          = need_q;
		sz_d            = sz_q;
		fsz_d           = fsz_q;
		flink_d         = flink_q;
		fwd_d           = fwd_q;
		res_addr_d      = res_addr_q;
		res_stat_d      = res_stat_q;
		out_valid_d     = out_valid_q && out_stall;
		block_address_d = block_address_q;
		status_d        = status_q;
		size_we         = 1'b0;
		link_we         = 1'b0;
		size_wa         = '0;
		link_wa         = '0;
		size_wd         = '0;
		link_wd         = '0;
		rd_idx          = '0;
		unique case (state_q)
			ST_CLR: begin
				size_we = 1'b1;
				link_we = 1'b1;
				size_wa = clr_q;
				link_wa = clr_q;
				clr_d   = clr_q + IW'(1);
			end
			ST_SEG: begin
				size_we = 1'b1;
				link_we = 1'b1;
				size_wa = base_q[IW+1:2];
				link_wa = base_q[IW+1:2];
				size_wd = piece_w;
				link_wd = base_q + piece_w;
				base_d  = base_q + piece_w;
			end
			ST_IDLE: begin
				res_addr_d = '0;
				if (in_valid) begin
					unique case (kind)
						KIND_ALLOC: begin
							res_stat_d = STAT_NULL;
							need_d     = need_w;
							q_d        = rover_q;
							n_d        = count_q;
							rd_idx     = rover_q[IW+1:2];
						end
						KIND_FREE: begin
							res_stat_d = (free_address == '0) ? STAT_NULL : STAT_BAD;
							x_d        = x_w;
							rd_idx     = x_w[IW+1:2];
						end
						default: res_stat_d = STAT_BAD;
					endcase
				end
			end
			ST_A_STEP: begin
				res_stat_d = STAT_BAD;
				n_d        = n_q - COUNT_W'(1);
				p_d        = link_rd;
				rd_idx     = link_rd[IW+1:2];
			end
			ST_A_CHK: begin
				priority if (walk_more) begin
					res_stat_d = STAT_BAD;
					q_d        = p_q;
					p_d        = link_rd;
					n_d        = n_q - COUNT_W'(1);
					rd_idx     = link_rd[IW+1:2];
				end else if (s_lt) begin
					res_stat_d = STAT_OOM;
				end else if (k_small) begin
					link_we    = 1'b1;
					link_wa    = q_q[IW+1:2];
					link_wd    = link_rd;
					rover_d    = q_q;
					count_d    = count_q - COUNT_W'(1);
					res_addr_d = 16'(p_q + HDR_C);
					res_stat_d = STAT_OK;
				end else begin
					size_we = 1'b1;
					size_wa = p_q[IW+1:2];
					size_wd = k_w;
					rover_d = p_q;
					p_d     = p_q + k_w;
				end
			end
			ST_A_SPLIT: begin
				size_we    = 1'b1;
				size_wa    = p_q[IW+1:2];
				size_wd    = need_q;
				res_addr_d = 16'(p_q + HDR_C);
				res_stat_d = STAT_OK;
			end
			ST_F_SZ: begin
				sz_d   = size_rd;
				q_d    = SENT_C;
				n_d    = count_q;
				rd_idx = SENT_C[IW+1:2];
			end
			ST_F_STEP: begin
				n_d    = n_q - COUNT_W'(1);
				rd_idx = link_rd[IW+1:2];
				if (link_rd <= x_q) begin
					q_d = link_rd;
				end else begin
					p_d = link_rd;
				end
			end
			ST_F_FWD: begin
				size_we = 1'b1;
				link_we = 1'b1;
				size_wa = x_q[IW+1:2];
				link_wa = x_q[IW+1:2];
				size_wd = fwd ? (sz_q + size_rd) : sz_q;
				link_wd = fwd ? link_rd : p_q;
				fsz_d   = size_wd;
				flink_d = link_wd;
				fwd_d   = fwd;
				if (fwd && rover_q == p_q) rover_d = x_q;
			end
			ST_F_RDQ: begin
				rd_idx = q_q[IW+1:2];
			end
			ST_F_BWD: begin
				size_we    = bwd;
				link_we    = 1'b1;
				size_wa    = q_q[IW+1:2];
				link_wa    = q_q[IW+1:2];
				size_wd    = size_rd + fsz_q;
				link_wd    = bwd ? flink_q : x_q;
				if (bwd && rover_q == x_q) rover_d = q_q;
				count_d    = count_q + COUNT_W'(1) - COUNT_W'(fwd_q) - COUNT_W'(bwd);
				res_addr_d = '0;
				res_stat_d = STAT_OK;
			end
			ST_DONE: begin
				if (slot_free) begin
					out_valid_d     = 1'b1;
					block_address_d = res_addr_q;
					status_d        = res_stat_q;
				end
			end
			default: begin
				res_stat_d = STAT_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			base_q      <= '0;
			rover_q     <= SENT_C;
			count_q     <= COUNT_W'(CNT_RST);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			base_q      <= base_d;
			rover_q     <= rover_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q             <= n_d;
		p_q             <= p_d;
		q_q             <= q_d;
		x_q             <= x_d;
		need_q          <= need_d;
		sz_q            <= sz_d;
		fsz_q           <= fsz_d;
		flink_q         <= flink_d;
		fwd_q           <= fwd_d;
		res_addr_q      <= res_addr_d;
		res_stat_q      <= res_stat_d;
		block_address_q <= block_address_d;
		status_q        <= status_d;
	end

endmodule
